// ----- hdl/ctgr_pkg.sv -----
// shared types, constants and font table of the clock time glyph renderer
`timescale 1ns / 1ps
`default_nettype none

package ctgr_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [3:0] GLYPH_COLON = 4'd10;
    localparam logic [3:0] GLYPH_A     = 4'd11;
    localparam logic [3:0] GLYPH_P     = 4'd12;
    localparam int         NUM_GLYPHS  = 13;

    typedef enum logic [2:0] {
        REG_USE_24_HOUR        = 3'd0,
        REG_PIXEL_THICKNESS    = 3'd1,
        REG_DRAW_COLOR         = 3'd2,
        REG_USE_CUSTOM_METRICS = 3'd3,
        REG_CUSTOM_DIGIT_WIDTH = 3'd4,
        REG_CUSTOM_COLON_WIDTH = 3'd5,
        REG_CUSTOM_SPACING     = 3'd6
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_LAST
    } state_t;

    // live register settings, thickness already forced to at least one
    typedef struct packed {
        logic        use_24_hour;
        logic [3:0]  thickness;
        logic [15:0] draw_color;
        logic        use_custom_metrics;
        logic [7:0]  custom_digit_width;
        logic [7:0]  custom_colon_width;
        logic [3:0]  custom_spacing;
    } cfg_t;

    // one classified request: glyph codes in drawing order
    typedef struct packed {
        logic              measure;
        logic signed [10:0] origin_x;
        logic signed [10:0] origin_y;
        logic              colon_visible;
        logic [2:0]        last_char;
        logic [5:0][3:0]   glyphs;
    } item_t;

    // bit 7 is the leftmost column
    localparam logic [7:0] FONT_ROM [0:NUM_GLYPHS-1][0:4] = '{
        '{8'he0, 8'ha0, 8'ha0, 8'ha0, 8'he0},
        '{8'h40, 8'h40, 8'h40, 8'h40, 8'h40},
        '{8'he0, 8'h20, 8'he0, 8'h80, 8'he0},
        '{8'he0, 8'h20, 8'h60, 8'h20, 8'he0},
        '{8'h80, 8'h80, 8'ha0, 8'he0, 8'h20},
        '{8'he0, 8'h80, 8'he0, 8'h20, 8'he0},
        '{8'he0, 8'h80, 8'he0, 8'ha0, 8'he0},
        '{8'he0, 8'h20, 8'h20, 8'h20, 8'h20},
        '{8'he0, 8'ha0, 8'he0, 8'ha0, 8'he0},
        '{8'he0, 8'ha0, 8'he0, 8'h20, 8'he0},
        '{8'h00, 8'h40, 8'h00, 8'h40, 8'h00},
        '{8'h40, 8'ha0, 8'he0, 8'ha0, 8'ha0},
        '{8'he0, 8'ha0, 8'he0, 8'h80, 8'h80}
    };

    // 15-bit pixel mask, bit row*3+col
    function automatic logic [14:0] glyph_mask(input logic [3:0] code);
        logic [14:0] m;
        m = '0;
        if (code <= GLYPH_P) begin
            for (int r = 0; r < 5; r++) begin
                for (int c = 0; c < 3; c++) begin
                    m[r*3+c] = FONT_ROM[code][r][7-c];
                end
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/clock_time_glyph_renderer.sv -----
// Renders a time of day as HH:MM (or HH:MM A/P) in a 3x5 bitmap font, as fill
// squares. A request is registered in a one-stage front end (hour reduction and
// minute clamp, with the digit split on the register output) and waits in a short
// queue; the drawing sequencer takes it from the queue when idle and, while the
// receiver is ready, emits one square per cycle for each lit font pixel. It also
// steps through each character that draws nothing (a hidden colon, or every
// character in measure mode), then emits the final width item. A drawn request
// has at most 62 lit pixels (in 12-hour mode). The sequencer is the limit: the
// front end accepts further requests until the queue is full.
// Registers are written through cfg_we/cfg_index/cfg_data; the user must write
// them only while the block is idle, and the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none

module clock_time_glyph_renderer
    import ctgr_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [15:0]       cfg_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              operation,
    input  wire logic signed [10:0] origin_x,
    input  wire logic signed [10:0] origin_y,
    input  wire logic [7:0]        hour,
    input  wire logic signed [7:0] minute,
    input  wire logic              colon_visible,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic                   rect_valid,
    output logic signed [11:0]     rect_x,
    output logic signed [11:0]     rect_y,
    output logic [3:0]             rect_size,
    output logic [15:0]            rect_color,
    output logic [10:0]            total_width,
    output logic                   last
);

    logic        use_24_hour_reg;
    logic [3:0]  thickness_reg;
    logic [15:0] draw_color_reg;
    logic        use_custom_reg;
    logic [7:0]  digit_width_reg;
    logic [7:0]  colon_width_reg;
    logic [3:0]  spacing_reg;

    cfg_t        cfg;
    logic        push_valid;
    logic        push_ready;
    item_t       push_data;
    logic        pop_valid;
    logic        pop_ready;
    item_t       pop_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_24_hour_reg <= 1'b1;
            thickness_reg   <= 4'd1;
            draw_color_reg  <= 16'hffff;
            use_custom_reg  <= 1'b0;
            digit_width_reg <= 8'd3;
            colon_width_reg <= 8'd1;
            spacing_reg     <= 4'd1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_USE_24_HOUR:        use_24_hour_reg <= cfg_data[0];
                REG_PIXEL_THICKNESS:    thickness_reg   <= cfg_data[3:0];
                REG_DRAW_COLOR:         draw_color_reg  <= cfg_data;
                REG_USE_CUSTOM_METRICS: use_custom_reg  <= cfg_data[0];
                REG_CUSTOM_DIGIT_WIDTH: digit_width_reg <= cfg_data[7:0];
                REG_CUSTOM_COLON_WIDTH: colon_width_reg <= cfg_data[7:0];
                REG_CUSTOM_SPACING:     spacing_reg     <= cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // zero thickness behaves as one
    always_comb
    begin
        cfg.use_24_hour        = use_24_hour_reg;
        cfg.thickness          = (thickness_reg == 4'd0) ? 4'd1 : thickness_reg;
        cfg.draw_color         = draw_color_reg;
        cfg.use_custom_metrics = use_custom_reg;
        cfg.custom_digit_width = digit_width_reg;
        cfg.custom_colon_width = colon_width_reg;
        cfg.custom_spacing     = spacing_reg;
    end

    ctgr_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .origin_x      (origin_x),
        .origin_y      (origin_y),
        .hour          (hour),
        .minute        (minute),
        .colon_visible (colon_visible),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_data     (push_data)
    );

    ctgr_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ctgr_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .pop_valid   (pop_valid),
        .pop_ready   (pop_ready),
        .pop_data    (pop_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .rect_valid  (rect_valid),
        .rect_x      (rect_x),
        .rect_y      (rect_y),
        .rect_size   (rect_size),
        .rect_color  (rect_color),
        .total_width (total_width),
        .last        (last)
    );

endmodule

`default_nettype wire

// ----- hdl/ctgr_front.sv -----
// front end: reduces the hour, clamps the minute and builds the glyph list
`timescale 1ns / 1ps
`default_nettype none

module ctgr_front
    import ctgr_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cfg_t              cfg,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              operation,
    input  wire logic signed [10:0] origin_x,
    input  wire logic signed [10:0] origin_y,
    input  wire logic [7:0]        hour,
    input  wire logic signed [7:0] minute,
    input  wire logic              colon_visible,
    output logic                   push_valid,
    input  wire logic              push_ready,
    output item_t                  push_data
);

    logic              s1_valid_reg, s1_valid_next;
    logic              s1_measure_reg;
    logic signed [10:0] s1_ox_reg;
    logic signed [10:0] s1_oy_reg;
    logic              s1_colon_reg;
    logic [4:0]        s1_hour_reg;
    logic              s1_pm_reg;
    logic [5:0]        s1_minute_reg;

    logic              take;
    logic [11:0]       hq_prod;
    logic [8:0]        hr_rem0;
    logic [4:0]        hr24;
    logic [4:0]        hr12;
    logic [4:0]        hr_sel;
    logic              pm;
    logic [5:0]        mn_clamp;
    logic [7:0]        hr_digits;
    logic [7:0]        mn_digits;

    // v / 10 by reciprocal, one correction step; returns {tens, ones}
    function automatic logic [7:0] split10(input logic [5:0] v);
        logic [10:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = {5'd0, v} * 11'd25;
        tens = {1'b0, prod[10:8]};
        ones = {1'b0, v} - ({3'd0, tens} * 7'd10);
        if (ones >= 7'd10) begin
            tens = tens + 4'd1;
            ones = ones - 7'd10;
        end
        return {tens, ones[3:0]};
    endfunction

    assign take     = in_valid && in_ready;
    assign in_ready = !s1_valid_reg || push_ready;

    // hour mod 24: quotient estimate low by at most one
    always_comb
    begin
        hq_prod = {4'd0, hour} * 12'd10;
        hr_rem0 = {1'b0, hour} - ({5'd0, hq_prod[11:8]} * 9'd24);
        hr24    = (hr_rem0 >= 9'd24) ? 5'(hr_rem0 - 9'd24) : hr_rem0[4:0];
        pm      = (hr24 >= 5'd12);
        if (hr24 == 5'd0)
            hr12 = 5'd12;
        else if (hr24 > 5'd12)
            hr12 = hr24 - 5'd12;
        else
            hr12 = hr24;
        hr_sel = cfg.use_24_hour ? hr24 : hr12;
        if (minute < 8'sd0)
            mn_clamp = 6'd0;
        else if (minute > 8'sd59)
            mn_clamp = 6'd59;
        else
            mn_clamp = minute[5:0];
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (take)
            s1_valid_next = 1'b1;
        else if (push_ready)
            s1_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            s1_measure_reg <= operation;
            s1_ox_reg      <= origin_x;
            s1_oy_reg      <= origin_y;
            s1_colon_reg   <= colon_visible;
            s1_hour_reg    <= hr_sel;
            s1_pm_reg      <= pm;
            s1_minute_reg  <= mn_clamp;
        end
    end

    always_comb
    begin
        hr_digits = split10({1'b0, s1_hour_reg});
        mn_digits = split10(s1_minute_reg);
        push_valid              = s1_valid_reg;
        push_data.measure       = s1_measure_reg;
        push_data.origin_x      = s1_ox_reg;
        push_data.origin_y      = s1_oy_reg;
        push_data.colon_visible = s1_colon_reg;
        push_data.last_char     = cfg.use_24_hour ? 3'd4 : 3'd5;
        push_data.glyphs[0]     = hr_digits[7:4];
        push_data.glyphs[1]     = hr_digits[3:0];
        push_data.glyphs[2]     = GLYPH_COLON;
        push_data.glyphs[3]     = mn_digits[7:4];
        push_data.glyphs[4]     = mn_digits[3:0];
        push_data.glyphs[5]     = s1_pm_reg ? GLYPH_P : GLYPH_A;
    end

endmodule

`default_nettype wire

// ----- hdl/ctgr_queue.sv -----
// short request queue between the front end and the drawing sequencer
`timescale 1ns / 1ps
`default_nettype none

module ctgr_queue
    import ctgr_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push_valid,
    output logic       push_ready,
    input  wire item_t push_data,
    output logic       pop_valid,
    input  wire logic  pop_ready,
    output item_t      pop_data
);

    // depth 2..16
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    item_t              entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_data;
    end

endmodule

`default_nettype wire

// ----- hdl/ctgr_back.sv -----
// drawing sequencer: walks the glyphs, emits one square per lit pixel, then the width
`timescale 1ns / 1ps
`default_nettype none

module ctgr_back
    import ctgr_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire cfg_t  cfg,
    input  wire logic  pop_valid,
    output logic       pop_ready,
    input  wire item_t pop_data,
    output logic       out_valid,
    input  wire logic  out_ready,
    output logic       rect_valid,
    output logic signed [11:0] rect_x,
    output logic signed [11:0] rect_y,
    output logic [3:0] rect_size,
    output logic [15:0] rect_color,
    output logic [10:0] total_width,
    output logic       last
);

    state_t      state_reg, state_next;
    item_t       item_reg, item_next;
    logic [2:0]  ci_reg, ci_next;
    logic [14:0] rem_reg, rem_next;
    logic [11:0] gx_reg, gx_next;

    logic        out_valid_reg, out_valid_next;
    logic        rect_valid_reg, rect_valid_next;
    logic [11:0] rect_x_reg, rect_x_next;
    logic [11:0] rect_y_reg, rect_y_next;
    logic [3:0]  rect_size_reg, rect_size_next;
    logic [15:0] rect_color_reg, rect_color_next;
    logic [10:0] total_reg, total_next;
    logic        last_reg, last_next;
    logic        load_out;

    logic        adv;
    logic [14:0] rem_clr;
    logic        char_done;
    logic        at_last;
    logic [2:0]  ci_inc;
    logic [3:0]  glyph_cur;
    logic [3:0]  glyph_inc;
    logic [8:0]  digit_adv;
    logic [8:0]  colon_adv;
    logic [11:0] adj_inc;
    logic [11:0] gx_step;
    logic [2:0]  sel_row;
    logic [1:0]  sel_col;
    logic [11:0] ox_ext;
    logic [11:0] oy_ext;

    function automatic logic [14:0] char_mask(input logic [3:0] code, input item_t it);
        logic [14:0] m;
        m = glyph_mask(code);
        if (it.measure || (code == GLYPH_COLON && !it.colon_visible))
            m = '0;
        return m;
    endfunction

    assign adv       = !out_valid_reg || out_ready;
    assign rem_clr   = rem_reg & (rem_reg - 15'd1);
    assign char_done = (rem_clr == '0);
    assign at_last   = (ci_reg == item_reg.last_char);
    assign ci_inc    = (ci_reg == 3'd5) ? ci_reg : ci_reg + 3'd1;
    assign glyph_cur = item_reg.glyphs[ci_reg];
    assign glyph_inc = item_reg.glyphs[ci_inc];
    assign ox_ext    = {item_reg.origin_x[10], item_reg.origin_x};
    assign oy_ext    = {item_reg.origin_y[10], item_reg.origin_y};

    // advance metrics; the colon slot steps back one column, the digit after it forward one
    always_comb
    begin
        if (cfg.use_custom_metrics)
        begin
            digit_adv = {1'b0, cfg.custom_digit_width} + {5'd0, cfg.custom_spacing};
            colon_adv = {1'b0, cfg.custom_colon_width} + {5'd0, cfg.custom_spacing};
        end
        else
        begin
            digit_adv = 9'({5'd0, cfg.thickness} * 9'd3) + 9'd1;
            colon_adv = {5'd0, cfg.thickness} + 9'd1;
        end
        case (ci_inc)
            3'd2:    adj_inc = 12'hfff;
            3'd3:    adj_inc = 12'd1;
            default: adj_inc = 12'd0;
        endcase
        if (at_last)
            adj_inc = 12'd0;
        gx_step = gx_reg + 12'(glyph_cur == GLYPH_COLON ? colon_adv : digit_adv) + adj_inc;
    end

    // lowest lit pixel: top row first, then leftmost column
    always_comb
    begin
        sel_row = 3'd0;
        sel_col = 2'd0;
        for (int r = 4; r >= 0; r--) begin
            for (int c = 2; c >= 0; c--) begin
                if (rem_reg[r*3+c])
                begin
                    sel_row = 3'(r);
                    sel_col = 2'(c);
                end
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                    state_next = ST_RUN;
            end
            ST_RUN:
            begin
                if (adv && char_done && at_last)
                    state_next = ST_LAST;
            end
            ST_LAST:
            begin
                if (adv)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pop_ready   = (state_reg == ST_IDLE);
        out_valid   = out_valid_reg;
        rect_valid  = rect_valid_reg;
        rect_x      = rect_x_reg;
        rect_y      = rect_y_reg;
        rect_size   = rect_size_reg;
        rect_color  = rect_color_reg;
        total_width = total_reg;
        last        = last_reg;
    end

    always_comb
    begin
        item_next       = item_reg;
        ci_next         = ci_reg;
        rem_next        = rem_reg;
        gx_next         = gx_reg;
        out_valid_next  = adv ? 1'b0 : out_valid_reg;
        load_out        = 1'b0;
        rect_valid_next = 1'b0;
        rect_x_next     = '0;
        rect_y_next     = '0;
        rect_size_next  = '0;
        rect_color_next = '0;
        total_next      = '0;
        last_next       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (pop_valid)
                begin
                    item_next = pop_data;
                    ci_next   = 3'd0;
                    gx_next   = {pop_data.origin_x[10], pop_data.origin_x};
                    rem_next  = char_mask(pop_data.glyphs[0], pop_data);
                end
            end
            ST_RUN:
            begin
                if (adv)
                begin
                    if (rem_reg != '0)
                    begin
                        out_valid_next  = 1'b1;
                        load_out        = 1'b1;
                        rect_valid_next = 1'b1;
                        rect_x_next     = gx_reg + 12'({2'd0, sel_col} * {4'd0, cfg.thickness});
                        rect_y_next     = oy_ext + 12'({1'b0, sel_row} * {3'd0, cfg.thickness});
                        rect_size_next  = cfg.thickness;
                        rect_color_next = cfg.draw_color;
                    end
                    rem_next = rem_clr;
                    if (char_done)
                    begin
                        gx_next = gx_step;
                        if (!at_last)
                        begin
                            ci_next  = ci_inc;
                            rem_next = char_mask(glyph_inc, item_reg);
                        end
                    end
                end
            end
            ST_LAST:
            begin
                if (adv)
                begin
                    out_valid_next = 1'b1;
                    load_out       = 1'b1;
                    total_next     = 11'(gx_reg - ox_ext);
                    last_next      = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        ci_reg   <= ci_next;
        rem_reg  <= rem_next;
        gx_reg   <= gx_next;
        if (load_out)
        begin
            rect_valid_reg <= rect_valid_next;
            rect_x_reg     <= rect_x_next;
            rect_y_reg     <= rect_y_next;
            rect_size_reg  <= rect_size_next;
            rect_color_reg <= rect_color_next;
            total_reg      <= total_next;
            last_reg       <= last_next;
        end
    end

    a_char_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (ci_reg <= item_reg.last_char))
        else $error("character index past end of string");

    a_last_no_rect: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && last_reg) |-> !rect_valid_reg)
        else $error("final item carries a square");

    a_rect_size: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && rect_valid_reg) |-> (rect_size_reg != 4'd0))
        else $error("square with zero size");

    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (pop_valid && pop_ready) |=> (state_reg == ST_RUN))
        else $error("request taken without starting a run");

    a_last_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LAST && adv) |=> (out_valid_reg && last_reg))
        else $error("run ended without a width item");

endmodule

`default_nettype wire

// ----- test/glyph_stream_checker.sv -----
// checker for the time glyph renderer: tracks register writes, predicts squares and compares
`timescale 1ns / 1ps

module glyph_stream_checker
    import ctgr_pkg::*;
#(
    parameter logic MEASURE_CODE = 1'b1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [15:0]       cfg_data,
    input  wire logic              in_valid,
    input  wire logic              in_ready,
    input  wire logic              operation,
    input  wire logic signed [10:0] origin_x,
    input  wire logic signed [10:0] origin_y,
    input  wire logic [7:0]        hour,
    input  wire logic signed [7:0] minute,
    input  wire logic              colon_visible,
    input  wire logic              out_valid,
    input  wire logic              out_ready,
    input  wire logic              rect_valid,
    input  wire logic signed [11:0] rect_x,
    input  wire logic signed [11:0] rect_y,
    input  wire logic [3:0]        rect_size,
    input  wire logic [15:0]       rect_color,
    input  wire logic [10:0]       total_width,
    input  wire logic              last,
    output int                     fail_count,
    output int                     pending,
    output int                     squares_seen,
    output int                     widths_seen
);

    typedef struct packed {
        logic        rect_valid;
        logic [11:0] rect_x;
        logic [11:0] rect_y;
        logic [3:0]  rect_size;
        logic [15:0] rect_color;
        logic [10:0] total_width;
        logic        last;
    } glyph_result_t;

    // 3x5 font, bit 7 is the leftmost column
    localparam logic [7:0] GLYPH_ROWS [13][5] = '{
        '{8'he0, 8'ha0, 8'ha0, 8'ha0, 8'he0},
        '{8'h40, 8'h40, 8'h40, 8'h40, 8'h40},
        '{8'he0, 8'h20, 8'he0, 8'h80, 8'he0},
        '{8'he0, 8'h20, 8'h60, 8'h20, 8'he0},
        '{8'h80, 8'h80, 8'ha0, 8'he0, 8'h20},
        '{8'he0, 8'h80, 8'he0, 8'h20, 8'he0},
        '{8'he0, 8'h80, 8'he0, 8'ha0, 8'he0},
        '{8'he0, 8'h20, 8'h20, 8'h20, 8'h20},
        '{8'he0, 8'ha0, 8'he0, 8'ha0, 8'he0},
        '{8'he0, 8'ha0, 8'he0, 8'h20, 8'he0},
        '{8'h00, 8'h40, 8'h00, 8'h40, 8'h00},
        '{8'h40, 8'ha0, 8'he0, 8'ha0, 8'ha0},
        '{8'he0, 8'ha0, 8'he0, 8'h80, 8'h80}
    };

    logic        mode_24_q;
    logic [3:0]  thickness_q;
    logic [15:0] color_q;
    logic        custom_q;
    logic [7:0]  digit_w_q;
    logic [7:0]  colon_w_q;
    logic [3:0]  spacing_q;

    glyph_result_t expected_results[$];

    function automatic void queue_glyph(int gx, int gy, logic [3:0] g, int t);
        glyph_result_t sq;
        for (int row = 0; row < 5; row++) begin
            for (int col = 0; col < 3; col++) begin
                if (GLYPH_ROWS[g][row][7-col]) begin
                    sq.rect_valid  = 1'b1;
                    sq.rect_x      = 12'(gx + col * t);
                    sq.rect_y      = 12'(gy + row * t);
                    sq.rect_size   = 4'(t);
                    sq.rect_color  = color_q;
                    sq.total_width = '0;
                    sq.last        = 1'b0;
                    expected_results.push_back(sq);
                end
            end
        end
    endfunction

    function automatic void render_time(logic measure, logic signed [10:0] ox,
                                        logic signed [10:0] oy, logic [7:0] hour_in,
                                        logic signed [7:0] minute_in, logic colon_on);
        int            t;
        int            dw;
        int            cw;
        int            sp;
        int            hr;
        int            mn;
        int            cur;
        int            nch;
        int            x0;
        logic [3:0]    chars [6];
        logic [3:0]    suffix;
        logic          after_colon;
        glyph_result_t fin;
        t = (thickness_q == 4'd0) ? 1 : int'(thickness_q);
        if (custom_q) begin
            dw = digit_w_q;
            cw = colon_w_q;
            sp = spacing_q;
        end
        else begin
            dw = 3 * t;
            cw = t;
            sp = 1;
        end
        hr = hour_in % 24;
        suffix = GLYPH_A;
        if (!mode_24_q) begin
            suffix = (hr >= 12) ? GLYPH_P : GLYPH_A;
            if (hr == 0)
                hr = 12;
            else if (hr > 12)
                hr = hr - 12;
        end
        mn = minute_in;
        if (mn < 0)
            mn = 0;
        if (mn > 59)
            mn = 59;
        chars[0] = 4'(hr / 10);
        chars[1] = 4'(hr % 10);
        chars[2] = GLYPH_COLON;
        chars[3] = 4'(mn / 10);
        chars[4] = 4'(mn % 10);
        chars[5] = suffix;
        nch = mode_24_q ? 5 : 6;

        x0 = ox;
        cur = x0;
        after_colon = 1'b0;
        for (int i = 0; i < nch; i++) begin
            if (chars[i] == GLYPH_COLON) begin
                // colon sits one column left, and the next digit one column right
                cur = cur - 1;
                if (!measure && colon_on)
                    queue_glyph(cur, oy, chars[i], t);
                cur = cur + cw + sp;
                after_colon = 1'b1;
            end
            else begin
                if (after_colon) begin
                    cur = cur + 1;
                    after_colon = 1'b0;
                end
                if (!measure)
                    queue_glyph(cur, oy, chars[i], t);
                cur = cur + dw + sp;
            end
        end
        fin = '0;
        fin.total_width = 11'(cur - x0);
        fin.last = 1'b1;
        expected_results.push_back(fin);
    endfunction

    always @(posedge clk or negedge rst_n) begin : monitor
        glyph_result_t want;
        logic          bad;
        if (!rst_n) begin
            mode_24_q    = 1'b1;
            thickness_q  = 4'd1;
            color_q      = 16'hffff;
            custom_q     = 1'b0;
            digit_w_q    = 8'd3;
            colon_w_q    = 8'd1;
            spacing_q    = 4'd1;
            fail_count   = 0;
            squares_seen = 0;
            widths_seen  = 0;
            expected_results.delete();
        end
        else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_USE_24_HOUR:        mode_24_q   = cfg_data[0];
                    REG_PIXEL_THICKNESS:    thickness_q = cfg_data[3:0];
                    REG_DRAW_COLOR:         color_q     = cfg_data;
                    REG_USE_CUSTOM_METRICS: custom_q    = cfg_data[0];
                    REG_CUSTOM_DIGIT_WIDTH: digit_w_q   = cfg_data[7:0];
                    REG_CUSTOM_COLON_WIDTH: colon_w_q   = cfg_data[7:0];
                    REG_CUSTOM_SPACING:     spacing_q   = cfg_data[3:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
                render_time(operation == MEASURE_CODE, origin_x, origin_y, hour, minute,
                            colon_visible);
            if (out_valid && out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result arrived with no request outstanding");
                    fail_count++;
                end
                else begin
                    want = expected_results.pop_front();
                    bad = 1'b0;
                    if (rect_valid !== want.rect_valid) begin
                        $error("rect_valid expected %0d got %0d", want.rect_valid, rect_valid);
                        bad = 1'b1;
                    end
                    if (rect_x !== want.rect_x) begin
                        $error("rect_x expected %0d got %0d", $signed(want.rect_x), rect_x);
                        bad = 1'b1;
                    end
                    if (rect_y !== want.rect_y) begin
                        $error("rect_y expected %0d got %0d", $signed(want.rect_y), rect_y);
                        bad = 1'b1;
                    end
                    if (rect_size !== want.rect_size) begin
                        $error("rect_size expected %0d got %0d", want.rect_size, rect_size);
                        bad = 1'b1;
                    end
                    if (rect_color !== want.rect_color) begin
                        $error("rect_color expected %h got %h", want.rect_color, rect_color);
                        bad = 1'b1;
                    end
                    if (total_width !== want.total_width) begin
                        $error("total_width expected %0d got %0d", want.total_width,
                               total_width);
                        bad = 1'b1;
                    end
                    if (last !== want.last) begin
                        $error("last expected %0d got %0d", want.last, last);
                        bad = 1'b1;
                    end
                    if (bad)
                        fail_count++;
                    if (want.last)
                        widths_seen++;
                    else
                        squares_seen++;
                end
            end
        end
        pending = expected_results.size();
    end

endmodule

// ----- test/tb_top.sv -----
// top of the time glyph renderer testbench: clock, reset, requests, settings and verdict
`timescale 1ns / 1ps

module tb_top;
    import ctgr_pkg::*;

    localparam logic       OP_DRAW     = 1'b0;
    localparam logic       OP_MEASURE  = 1'b1;
    localparam logic [2:0] REG_UNUSED  = 3'd7;
    localparam int         IDLE_LIMIT  = 4000;
    localparam int         RANDOM_SETS = 8;
    localparam int         PER_SET     = 55;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [2:0]        cfg_index;
    logic [15:0]       cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic              operation;
    logic signed [10:0] origin_x;
    logic signed [10:0] origin_y;
    logic [7:0]        hour;
    logic signed [7:0] minute;
    logic              colon_visible;
    logic              out_valid;
    logic              out_ready;
    logic              rect_valid;
    logic signed [11:0] rect_x;
    logic signed [11:0] rect_y;
    logic [3:0]        rect_size;
    logic [15:0]       rect_color;
    logic [10:0]       total_width;
    logic              last;

    int fail_count;
    int pending;
    int squares_seen;
    int widths_seen;
    int requests_sent;
    int measures_sent;
    int settings_used;
    int idle_cycles;
    int ready_hold;
    logic quiet;

    clock_time_glyph_renderer DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .origin_x      (origin_x),
        .origin_y      (origin_y),
        .hour          (hour),
        .minute        (minute),
        .colon_visible (colon_visible),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .rect_valid    (rect_valid),
        .rect_x        (rect_x),
        .rect_y        (rect_y),
        .rect_size     (rect_size),
        .rect_color    (rect_color),
        .total_width   (total_width),
        .last          (last)
    );

    glyph_stream_checker #(
        .MEASURE_CODE (OP_MEASURE)
    ) u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .operation     (operation),
        .origin_x      (origin_x),
        .origin_y      (origin_y),
        .hour          (hour),
        .minute        (minute),
        .colon_visible (colon_visible),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .rect_valid    (rect_valid),
        .rect_x        (rect_x),
        .rect_y        (rect_y),
        .rect_size     (rect_size),
        .rect_color    (rect_color),
        .total_width   (total_width),
        .last          (last),
        .fail_count    (fail_count),
        .pending       (pending),
        .squares_seen  (squares_seen),
        .widths_seen   (widths_seen)
    );

    initial clk = 1'b0;

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    // a range end now and then, otherwise anything in range
    function automatic int pick_edge(int lo, int hi);
        int r;
        r = $urandom_range(0, 7);
        if (r == 0)
            return lo;
        else if (r == 1)
            return hi;
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    // receiver back-pressure
    always @(posedge clk)
    begin
        if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
            out_ready <= 1'b0;
        end
        else if (rst_n && !quiet && $urandom_range(0, 7) == 0) begin
            ready_hold = pick_gap() - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= rst_n;
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles = idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_request(logic op, logic signed [10:0] ox, logic signed [10:0] oy,
                                logic [7:0] hr, logic signed [7:0] mn, logic colon_on);
        in_valid      <= 1'b1;
        operation     <= op;
        origin_x      <= ox;
        origin_y      <= oy;
        hour          <= hr;
        minute        <= mn;
        colon_visible <= colon_on;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        requests_sent++;
        if (op == OP_MEASURE)
            measures_sent++;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat (pick_gap()) @(posedge clk);
        end
    endtask

    task automatic send_random_request();
        logic              op;
        logic signed [10:0] ox;
        logic signed [10:0] oy;
        logic [7:0]        hr;
        logic signed [7:0] mn;
        op = ($urandom_range(0, 4) == 0) ? OP_MEASURE : OP_DRAW;
        ox = 11'(pick_edge(-1024, 1023));
        oy = 11'(pick_edge(-1024, 1023));
        hr = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 23)) : 8'($urandom);
        mn = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 59)) : 8'($urandom);
        send_request(op, ox, oy, hr, mn, 1'($urandom));
    endtask

    // writes every register back to back, plus one write to an index with no register
    task automatic apply_settings(logic mode_24, logic [3:0] thick, logic [15:0] color,
                                  logic custom, logic [7:0] dw, logic [7:0] cw,
                                  logic [3:0] sp);
        logic [2:0]  idx [8];
        logic [15:0] val [8];
        idx = '{REG_USE_24_HOUR, REG_PIXEL_THICKNESS, REG_DRAW_COLOR,
                REG_USE_CUSTOM_METRICS, REG_CUSTOM_DIGIT_WIDTH, REG_CUSTOM_COLON_WIDTH,
                REG_CUSTOM_SPACING, REG_UNUSED};
        val = '{16'(mode_24), 16'(thick), color, 16'(custom), 16'(dw), 16'(cw),
                16'(sp), 16'($urandom)};
        for (int i = 0; i < 8; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        settings_used++;
    endtask

    // block must be idle before the next register write
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        in_valid      = 1'b0;
        operation     = OP_DRAW;
        origin_x      = '0;
        origin_y      = '0;
        hour          = '0;
        minute        = '0;
        colon_visible = 1'b0;
        out_ready     = 1'b0;
        quiet         = 1'b0;
        ready_hold    = 0;
        idle_cycles   = 0;
        requests_sent = 0;
        measures_sent = 0;
        settings_used = 1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // reset settings: 24 hour, thickness one, derived metrics
        send_request(OP_DRAW, 11'sd0, 11'sd0, 8'd0, 8'sd0, 1'b1);
        send_request(OP_DRAW, -11'sd1024, -11'sd1024, 8'd23, 8'sd59, 1'b1);
        send_request(OP_DRAW, 11'sd1023, 11'sd1023, 8'd255, 8'sd127, 1'b0);
        send_request(OP_MEASURE, 11'sd5, -11'sd7, 8'd12, -8'sd128, 1'b1);
        send_request(OP_DRAW, 11'sd100, 11'sd20, 8'd14, 8'sd60, 1'b1);
        send_request(OP_DRAW, -11'sd1, 11'sd1, 8'd24, -8'sd1, 1'b1);
        send_request(OP_DRAW, 11'sd300, -11'sd300, 8'd7, 8'sd28, 1'b1);
        drain();

        // 12 hour, zero thickness
        apply_settings(1'b0, 4'd0, 16'h0000, 1'b0, 8'd0, 8'd0, 4'd0);
        send_request(OP_DRAW, 11'sd10, 11'sd10, 8'd0, 8'sd5, 1'b1);
        send_request(OP_DRAW, 11'sd10, 11'sd10, 8'd12, 8'sd30, 1'b1);
        send_request(OP_DRAW, 11'sd10, 11'sd10, 8'd13, 8'sd45, 1'b1);
        send_request(OP_DRAW, 11'sd10, 11'sd10, 8'd11, 8'sd36, 1'b0);
        send_request(OP_MEASURE, 11'sd0, 11'sd0, 8'd0, 8'sd0, 1'b1);
        send_request(OP_DRAW, -11'sd50, 11'sd50, 8'd128, 8'sd19, 1'b1);
        drain();

        // widest custom metrics, thickest pixels, edge origins
        apply_settings(1'b0, 4'd15, 16'hffff, 1'b1, 8'd255, 8'd255, 4'd15);
        send_request(OP_DRAW, 11'sd1023, 11'sd1023, 8'd18, 8'sd18, 1'b1);
        send_request(OP_MEASURE, 11'sd0, 11'sd0, 8'd6, 8'sd6, 1'b1);
        send_request(OP_DRAW, -11'sd1024, -11'sd1024, 8'd12, 8'sd0, 1'b1);
        send_request(OP_DRAW, 11'sd0, 11'sd1000, 8'd23, 8'sd59, 1'b0);
        drain();

        apply_settings(1'b1, 4'd15, 16'h5a5a, 1'b0, 8'd17, 8'd9, 4'd3);
        send_request(OP_DRAW, 11'sd1023, -11'sd2, 8'd8, 8'sd88, 1'b1);
        send_request(OP_MEASURE, -11'sd1024, 11'sd0, 8'd19, 8'sd42, 1'b1);
        drain();

        for (int s = 0; s < RANDOM_SETS; s++) begin
            quiet = (s % 4 == 3);
            apply_settings(1'($urandom), 4'(pick_edge(0, 15)), 16'(pick_edge(0, 65535)),
                           1'($urandom), 8'(pick_edge(0, 255)), 8'(pick_edge(0, 255)),
                           4'(pick_edge(0, 15)));
            for (int k = 0; k < PER_SET; k++)
                send_random_request();
            drain();
        end
        quiet = 1'b0;

        $display("run covered %0d requests (%0d measure only) over %0d register settings",
                 requests_sent, measures_sent, settings_used);
        $display("checked %0d squares and %0d width results", squares_seen, widths_seen);
        if (fail_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// ----- filelist.f -----
hdl/ctgr_pkg.sv
hdl/ctgr_front.sv
hdl/ctgr_queue.sv
hdl/ctgr_back.sv
hdl/clock_time_glyph_renderer.sv
test/glyph_stream_checker.sv
test/tb_top.sv
